// ===== hdl/tlfs_pkg.sv =====
package tlfs_pkg;

	localparam int ID_W    = 4;
	localparam int LEN_W   = 16;
	localparam int TIME_W  = 32;
	localparam int LEVELS  = 3;
	localparam logic [1:0] LAST_LEVEL = 2'd2;

	// configuration register indexes
	localparam logic CFG_QUANTUM0 = 1'b0;
	localparam logic CFG_QUANTUM1 = 1'b1;

	// input kinds carried on tuser
	localparam logic FUNC_READY = 1'b0;
	localparam logic FUNC_TICK  = 1'b1;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_CHK  = 5'b00010,
		ST_SEL  = 5'b00100,
		ST_HEAD = 5'b01000,
		ST_RUN  = 5'b10000
	} state_t;

	typedef struct packed {
		logic ready_wr;
		logic tick_start;
		logic chk;
		logic sel;
		logic head;
		logic run;
	} cmd_t;

	typedef struct packed {
		logic out_valid;
	} status_t;

	// per-process record
	typedef struct packed {
		logic [LEN_W-1:0] burst;
		logic [LEN_W-1:0] quant;
		logic [1:0]       lvl;
	} proc_rec_t;

endpackage

// ===== hdl/tlfs_ctrl.sv =====
module tlfs_ctrl import tlfs_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	input  logic    s_tuser,
	output logic    s_tready,
	input  logic    m_tready,
	input  status_t stat,
	output cmd_t    cmd
);

	state_t state_q, state_d;
	logic   accept;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	// commands to the datapath
	always_comb begin
		cmd            = '0;
		cmd.ready_wr   = accept && (s_tuser == FUNC_READY);
		cmd.tick_start = accept && (s_tuser == FUNC_TICK);
		cmd.chk        = (state_q == ST_CHK);
		cmd.sel        = (state_q == ST_SEL);
		cmd.head       = (state_q == ST_HEAD);
		cmd.run        = (state_q == ST_RUN) && (!stat.out_valid || m_tready);
	end

	// sequencer for one tick request
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (cmd.tick_start) state_d = ST_CHK;
			ST_CHK:  state_d = ST_SEL;
			ST_SEL:  state_d = ST_HEAD;
			ST_HEAD: state_d = ST_RUN;
			ST_RUN:  if (cmd.run) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_chk_to_sel: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CHK |=> state_q == ST_SEL)
		else $error("check step not followed by level select");
	a_run_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.run |-> (!stat.out_valid || m_tready))
		else $error("result written over a pending one");
	a_busy_no_req: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !cmd.ready_wr && !cmd.tick_start)
		else $error("request taken while a tick is in progress");

endmodule

// ===== hdl/tlfs_dp.sv =====
module tlfs_dp import tlfs_pkg::*; #(
	parameter int NUM_PROCS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output status_t     stat,
	input  logic [23:0] s_tdata,
	input  logic        cfg_valid,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        m_tready,
	output logic        m_tvalid,
	output logic [63:0] m_tdata
);

	localparam int PW = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
	localparam int CW = $clog2(NUM_PROCS + 1);
	localparam int QD = LEVELS * NUM_PROCS;
	localparam int AW = $clog2(QD);

	logic [ID_W-1:0]  in_pid;
	logic [LEN_W-1:0] in_blen;
	assign in_pid  = s_tdata[3:0];
	assign in_blen = s_tdata[19:4];

	logic [LEN_W-1:0] q0_q, q1_q;
	logic [NUM_PROCS-1:0] queued_q;
	logic [PW-1:0]    head_q  [LEVELS];
	logic [CW-1:0]    count_q [LEVELS];
	logic [ID_W-1:0]  cur_q;
	logic             busy_q;
	logic [LEN_W-1:0] sticks_q;
	logic [TIME_W-1:0] sbegin_q, tick_q;
	logic [1:0]       sel_lvl_q;
	logic             sel_any_q, disp_q;
	logic             rep_v_q, rep_idle_q, rep_done_q;
	logic [ID_W-1:0]  rep_id_q;
	logic [TIME_W-1:0] rep_start_q;
	logic [LEN_W-1:0] rep_len_q;
	logic             m_tvalid_q;
	logic [63:0]      m_tdata_q;

	logic [ID_W-1:0] qmem [QD];
	logic [ID_W-1:0] qrd_q;
	proc_rec_t       pmem [NUM_PROCS];
	proc_rec_t       prd_q;

	function automatic logic [LEN_W-1:0] lvl_quantum(input logic [1:0] l,
		input logic [LEN_W-1:0] a, input logic [LEN_W-1:0] b);
		logic [LEN_W-1:0] q;
		q = '0;
		if (l == 2'd0) q = (a != '0) ? a : LEN_W'(1);
		else if (l == 2'd1) q = (b != '0) ? b : LEN_W'(1);
		return q;
	endfunction

	function automatic logic [PW-1:0] wrap(input logic [PW:0] v);
		logic [PW:0] r;
		r = (v >= (PW+1)'(NUM_PROCS)) ? v - (PW+1)'(NUM_PROCS) : v;
		return r[PW-1:0];
	endfunction

	function automatic logic [AW-1:0] qaddr(input logic [1:0] l, input logic [PW-1:0] s);
		return AW'(32'(l) * NUM_PROCS) + AW'(s);
	endfunction

	// ready request
	logic pid_ok, rdy_push;
	assign pid_ok   = 32'(in_pid) < NUM_PROCS;
	assign rdy_push = cmd.ready_wr && pid_ok && !queued_q[PW'(in_pid)]
		&& (count_q[0] < CW'(NUM_PROCS));

	// check step: burst done or quantum expiry of the running process
	logic [1:0] chk_lvl;
	logic       chk_done, chk_move;
	assign chk_lvl  = (prd_q.lvl > LAST_LEVEL) ? LAST_LEVEL : prd_q.lvl;
	assign chk_done = cmd.chk && busy_q && (prd_q.burst == '0);
	assign chk_move = cmd.chk && busy_q && (prd_q.burst != '0)
		&& (chk_lvl < LAST_LEVEL) && (prd_q.quant == '0);

	// select the highest non-empty level
	logic [1:0] sel_lvl;
	logic       sel_any;
	always_comb begin
		sel_any = 1'b1;
		if (count_q[0] != '0) sel_lvl = 2'd0;
		else if (count_q[1] != '0) sel_lvl = 2'd1;
		else begin
			sel_lvl = 2'd2;
			sel_any = (count_q[2] != '0);
		end
	end

	// head step: dispatch decision
	logic disp;
	assign disp = cmd.head && sel_any_q && (!busy_q || qrd_q != cur_q);

	// run step: quantum load and one tick of work
	logic [LEN_W-1:0] run_q, run_nq, run_nb;
	always_comb begin
		run_q = prd_q.quant;
		if (disp_q && sel_lvl_q < LAST_LEVEL && prd_q.quant == '0)
			run_q = lvl_quantum(sel_lvl_q, q0_q, q1_q);
		run_nb = (prd_q.burst != '0) ? prd_q.burst - 1'b1 : prd_q.burst;
		run_nq = (prd_q.lvl < LAST_LEVEL && run_q != '0) ? run_q - 1'b1 : run_q;
	end

	// queue memory write port
	logic            qwe;
	logic [AW-1:0]   qwaddr;
	logic [ID_W-1:0] qwdata;
	logic [1:0]      nxt_lvl;
	logic [PW-1:0]   nxt_tail;
	always_comb begin
		nxt_lvl  = chk_lvl + 2'd1;
		nxt_tail = wrap((PW+1)'(head_q[nxt_lvl]) + (PW+1)'(count_q[nxt_lvl]));
		qwe    = rdy_push || chk_move;
		qwaddr = chk_move ? qaddr(nxt_lvl, nxt_tail)
			: qaddr(2'd0, wrap((PW+1)'(head_q[0]) + (PW+1)'(count_q[0])));
		qwdata = chk_move ? cur_q : in_pid;
	end

	// process memory ports
	logic          pwe;
	logic [PW-1:0] pwaddr, praddr;
	proc_rec_t     pwdata;
	always_comb begin
		pwe    = rdy_push || chk_move || (cmd.run && busy_q);
		pwaddr = rdy_push ? PW'(in_pid) : PW'(cur_q);
		if (rdy_push) begin
			pwdata.burst = (in_blen != '0) ? in_blen : LEN_W'(1);
			pwdata.quant = '0;
			pwdata.lvl   = 2'd0;
		end else if (chk_move) begin
			pwdata.burst = prd_q.burst;
			pwdata.quant = lvl_quantum(nxt_lvl, q0_q, q1_q);
			pwdata.lvl   = nxt_lvl;
		end else begin
			pwdata.burst = run_nb;
			pwdata.quant = run_nq;
			pwdata.lvl   = prd_q.lvl;
		end
		praddr = (cmd.head && disp) ? PW'(qrd_q) : PW'(cur_q);
	end

	always_ff @(posedge clk) begin
		if (qwe) qmem[qwaddr] <= qwdata;
		if (cmd.sel) qrd_q <= qmem[qaddr(sel_lvl, head_q[sel_lvl])];
	end

	always_ff @(posedge clk) begin
		if (pwe) pmem[pwaddr] <= pwdata;
		if (cmd.tick_start || cmd.head) prd_q <= pmem[praddr];
	end

	// scheduler state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q0_q       <= LEN_W'(4);
			q1_q       <= LEN_W'(8);
			queued_q   <= '0;
			for (int i = 0; i < LEVELS; i++) begin
				head_q[i]  <= '0;
				count_q[i] <= '0;
			end
			cur_q      <= '0;
			busy_q     <= 1'b0;
			sticks_q   <= '0;
			sbegin_q   <= '0;
			tick_q     <= '0;
			sel_lvl_q  <= '0;
			sel_any_q  <= 1'b0;
			disp_q     <= 1'b0;
			rep_v_q    <= 1'b0;
			rep_idle_q <= 1'b0;
			rep_done_q <= 1'b0;
			rep_id_q   <= '0;
			rep_start_q <= '0;
			rep_len_q  <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == CFG_QUANTUM0) q0_q <= cfg_data;
				if (cfg_index == CFG_QUANTUM1) q1_q <= cfg_data;
			end
			if (rdy_push) begin
				queued_q[PW'(in_pid)] <= 1'b1;
				count_q[0] <= count_q[0] + 1'b1;
			end
			if (cmd.tick_start) begin
				rep_v_q    <= 1'b0;
				rep_idle_q <= 1'b0;
				rep_done_q <= 1'b0;
				rep_id_q   <= '0;
				rep_start_q <= '0;
				rep_len_q  <= '0;
			end
			// running process always sits at the head of its level
			if (chk_done || chk_move) begin
				head_q[chk_lvl]  <= wrap((PW+1)'(head_q[chk_lvl]) + (PW+1)'(1));
				count_q[chk_lvl] <= count_q[chk_lvl] - 1'b1;
			end
			if (chk_move) count_q[nxt_lvl] <= count_q[nxt_lvl] + 1'b1;
			if (chk_done) begin
				queued_q[PW'(cur_q)] <= 1'b0;
				rep_v_q     <= 1'b1;
				rep_id_q    <= cur_q;
				rep_start_q <= sbegin_q;
				rep_len_q   <= sticks_q;
				rep_done_q  <= 1'b1;
				busy_q      <= 1'b0;
				sbegin_q    <= tick_q;
				sticks_q    <= '0;
			end
			if (cmd.sel) begin
				sel_lvl_q <= sel_lvl;
				sel_any_q <= sel_any;
			end
			if (cmd.head) disp_q <= disp;
			if (disp) begin
				if (sticks_q != '0) begin
					rep_v_q     <= 1'b1;
					rep_idle_q  <= !busy_q;
					rep_id_q    <= busy_q ? cur_q : '0;
					rep_start_q <= sbegin_q;
					rep_len_q   <= sticks_q;
					rep_done_q  <= 1'b0;
				end
				cur_q    <= qrd_q;
				busy_q   <= 1'b1;
				sbegin_q <= tick_q;
				sticks_q <= '0;
			end
			if (cmd.run) begin
				if (sticks_q != '1) sticks_q <= sticks_q + 1'b1;
				tick_q     <= tick_q + 1'b1;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.run) begin
			m_tdata_q <= {4'b0, rep_done_q, rep_len_q, rep_start_q, rep_id_q,
				rep_idle_q, rep_v_q, busy_q, busy_q ? cur_q : 4'b0};
		end
	end

	assign m_tvalid       = m_tvalid_q;
	assign m_tdata        = m_tdata_q;
	assign stat.out_valid = m_tvalid_q;

	a_counts: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q[0]) + 32'(count_q[1]) + 32'(count_q[2]) <= NUM_PROCS)
		else $error("queue occupancy exceeds process count");
	a_busy_queued: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> queued_q[PW'(cur_q)])
		else $error("running process not held in a queue");
	a_out_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(cmd.run))
		else $error("result raised without a run step");

endmodule

// ===== hdl/three_level_feedback_scheduler_top.sv =====
// Channel | Direction | Handshake                 | Payload
// s_      | in        | s_tvalid / s_tready       | s_tdata, s_tuser (kind)
// m_      | out       | m_tvalid / m_tready       | m_tdata (one result per tick)
// cfg_    | in        | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// A ready request is handled in the cycle it is accepted. A tick request goes
// through accept, check, level select, head read and run, set by the single
// read port of the queue memory and the per-process memory; a result not yet
// taken holds the run step. Reset is asynchronous and clears all queues at
// once; no clearing pass. Configuration writes are accepted in every cycle.
module three_level_feedback_scheduler_top import tlfs_pkg::*; #(
	parameter int NUM_PROCS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // proc_id[3:0], burst_len[19:4]
	input  logic        s_tuser,   // func
	output logic        m_tvalid,
	input  logic        m_tready,
	// running_id[3:0], running_valid[4], slice_valid[5], slice_idle[6],
	// slice_id[10:7], slice_start[42:11], slice_length[58:43], burst_done[59]
	output logic [63:0] m_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	cmd_t    cmd;
	status_t stat;

	assign cfg_ready = 1'b1;

	tlfs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tready (s_tready),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	tlfs_dp #(.NUM_PROCS(NUM_PROCS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.s_tdata   (s_tdata),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata)
	);

endmodule
